// File: design/pbpw_pkg.sv
// Package for the Bezier path walker: sizes, point table, codes and microcode program.
package pbpw_pkg;

    localparam int NUM_SEGMENTS    = 6;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int NUM_POINTS      = 3 * NUM_SEGMENTS + 1;
    localparam int TABLE_POINTS    = 19;

    // Port widths fixed by the interface.
    localparam int IDX_W     = 5;
    localparam int PT_W      = 16;
    localparam int POS_W     = 24;
    localparam int SEG_W     = 3;
    localparam int STEP_W    = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 24;

    // Curve parameter and datapath widths.
    localparam int T_W    = PARAM_FRAC_BITS + 1;
    localparam int W_W    = T_W + 2;
    localparam int PA_W   = W_W + 1;
    localparam int PB_W   = (T_W + 1 > PT_W + 2) ? T_W + 1 : PT_W + 2;
    localparam int P_W    = PA_W + PB_W;
    localparam int ACC_W  = P_W + 2;
    localparam int CV_W   = ACC_W - PARAM_FRAC_BITS;
    localparam int S_W    = ((CV_W > POS_W) ? CV_W : POS_W) + 1;

    localparam logic [T_W-1:0]   T_ONE    = T_W'(1) << PARAM_FRAC_BITS;
    localparam logic [P_W-1:0]   RND_HALF = P_W'(1) << (PARAM_FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (PARAM_FRAC_BITS - 1);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(328);
    localparam logic signed [S_W-1:0] POS_MAX = S_W'(8388607);
    localparam logic signed [S_W-1:0] POS_MIN = -S_W'(8388608);

    // Input operation codes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = CFG_IDX_W'(3);

    localparam int PC_W = 4;

    typedef enum logic [2:0] {
        UOP_DISPATCH,
        UOP_SQUARE,
        UOP_CUBE_U,
        UOP_CUBE_T,
        UOP_MAC,
        UOP_ROUND,
        UOP_FINISH,
        UOP_LOAD
    } t_uop;

    typedef enum logic {
        COND_NONE,
        COND_LOAD
    } t_cond;

    typedef struct packed {
        t_uop            op;
        t_cond           cond;
        logic [1:0]      ofs;
        logic [PC_W-1:0] target;
        logic            last;
    } t_uword;

    localparam logic [PC_W-1:0] PC_LOAD = PC_W'(10);

    // The program: dispatch, weights, four multiply-accumulates, round, finish; loads branch to a load step.
    function automatic t_uword uc_rom(input logic [PC_W-1:0] a);
        t_uword w;
        w = '{op: UOP_DISPATCH, cond: COND_NONE, ofs: 2'd0, target: '0, last: 1'b1};
        unique case (a)
            PC_W'(0):  w = '{UOP_DISPATCH, COND_LOAD, 2'd0, PC_LOAD, 1'b0};
            PC_W'(1):  w = '{UOP_SQUARE,   COND_NONE, 2'd0, '0, 1'b0};
            PC_W'(2):  w = '{UOP_CUBE_U,   COND_NONE, 2'd0, '0, 1'b0};
            PC_W'(3):  w = '{UOP_CUBE_T,   COND_NONE, 2'd0, '0, 1'b0};
            PC_W'(4):  w = '{UOP_MAC,      COND_NONE, 2'd0, '0, 1'b0};
            PC_W'(5):  w = '{UOP_MAC,      COND_NONE, 2'd1, '0, 1'b0};
            PC_W'(6):  w = '{UOP_MAC,      COND_NONE, 2'd2, '0, 1'b0};
            PC_W'(7):  w = '{UOP_MAC,      COND_NONE, 2'd3, '0, 1'b0};
            PC_W'(8):  w = '{UOP_ROUND,    COND_NONE, 2'd0, '0, 1'b0};
            PC_W'(9):  w = '{UOP_FINISH,   COND_NONE, 2'd0, '0, 1'b1};
            PC_LOAD:   w = '{UOP_LOAD,     COND_NONE, 2'd0, '0, 1'b1};
            default:   w = '{UOP_DISPATCH, COND_NONE, 2'd0, '0, 1'b1};
        endcase
        return w;
    endfunction

    // Reset path, x coordinates in Q7.8.
    function automatic logic signed [PT_W-1:0] init_x(input int i);
        logic signed [PT_W-1:0] v;
        v = '0;
        unique case (i)
            1: v = 16'sd584;    2: v = 16'sd1009;   3: v = 16'sd1147;
            4: v = 16'sd1203;   5: v = 16'sd1065;   6: v = 16'sd768;
            7: v = 16'sd420;    8: v = -16'sd118;   9: v = -16'sd440;
            10: v = -16'sd773;  11: v = -16'sd440;  12: v = -16'sd31;
            13: v = 16'sd512;   14: v = 16'sd148;   15: v = -16'sd353;
            16: v = -16'sd1075; 17: v = -16'sd297;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Reset path, z coordinates in Q7.8.
    function automatic logic signed [PT_W-1:0] init_z(input int i);
        logic signed [PT_W-1:0] v;
        v = '0;
        unique case (i)
            1: v = -16'sd77;    2: v = -16'sd435;   3: v = -16'sd881;
            4: v = -16'sd1398;  5: v = -16'sd1894;  6: v = -16'sd2043;
            7: v = -16'sd2140;  8: v = -16'sd2094;  9: v = -16'sd1705;
            10: v = -16'sd1229; 11: v = -16'sd1162; 12: v = -16'sd1116;
            13: v = -16'sd1085; 14: v = -16'sd819;  15: v = -16'sd486;
            16: v = 16'sd61;    17: v = 16'sd67;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: design/piecewise_bezier_path_walker_core.sv
// Top level of the Bezier path walker: microcoded sequencer over a two-multiplier datapath.
//
//  Channel   Direction  Handshake                 Word
//  input     in         i_valid / o_ready         i_op, i_point_index, i_point_x, i_point_z
//  result    out        o_valid / i_ready         o_pos_x, o_pos_y, o_pos_z, o_segment_used
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A tick runs the program from its dispatch step to its finish step, which writes the
// result word; no new word is taken until the program ends. A load runs the dispatch
// step, then the load step. The time a tick takes is set by the program length:
// two multipliers are shared by the weight steps and the four multiply-accumulates.
// Reset is synchronous and active low; it restores the registers, the curve parameter,
// the segment and the fixed control point path. The finish step waits while an earlier
// result word is still held, so a stalled result never gets lost or overwritten.
module piecewise_bezier_path_walker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [pbpw_pkg::IDX_W-1:0]        i_point_index,
    input  logic signed [pbpw_pkg::PT_W-1:0]  i_point_x,
    input  logic signed [pbpw_pkg::PT_W-1:0]  i_point_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [pbpw_pkg::POS_W-1:0] o_pos_x,
    output logic signed [pbpw_pkg::POS_W-1:0] o_pos_y,
    output logic signed [pbpw_pkg::POS_W-1:0] o_pos_z,
    output logic [pbpw_pkg::SEG_W-1:0]        o_segment_used,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pbpw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pbpw_pkg::CFG_W-1:0]        i_cfg_data
);
    import pbpw_pkg::*;

    // Sequencer state.
    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            n_busy;

    // Latched input word.
    logic                   r_op;
    logic [IDX_W-1:0]       r_idx;
    logic signed [PT_W-1:0] r_px;
    logic signed [PT_W-1:0] r_pz;

    // Configuration registers.
    logic [STEP_W-1:0]       r_step;
    logic signed [POS_W-1:0] r_cx;
    logic signed [POS_W-1:0] r_cy;
    logic signed [POS_W-1:0] r_cz;

    // Walk state and control point store.
    logic [T_W-1:0]         r_t;
    logic [SEG_W-1:0]       r_seg;
    logic signed [PT_W-1:0] r_cpx [NUM_POINTS];
    logic signed [PT_W-1:0] r_cpz [NUM_POINTS];

    // Datapath registers.
    logic [T_W-1:0]          r_t2;
    logic [T_W-1:0]          r_u2;
    logic [W_W-1:0]          r_w [4];
    logic signed [ACC_W-1:0] r_acc_x;
    logic signed [ACC_W-1:0] r_acc_z;
    logic signed [CV_W-1:0]  r_cv_x;
    logic signed [CV_W-1:0]  r_cv_z;

    // Result register.
    logic                    r_o_valid;
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_y;
    logic signed [POS_W-1:0] r_pos_z;
    logic [SEG_W-1:0]        r_seg_used;

    // Combinational datapath.
    t_uword                  uw;
    logic                    in_acc;
    logic                    stall;
    logic [T_W-1:0]          t_c;
    logic [T_W-1:0]          u_c;
    logic [IDX_W-1:0]        pidx;
    logic signed [PT_W+1:0]  px4;
    logic signed [PT_W+1:0]  pz4;
    logic signed [PA_W-1:0]  ma_a;
    logic signed [PB_W-1:0]  mb_a;
    logic signed [PA_W-1:0]  ma_b;
    logic signed [PB_W-1:0]  mb_b;
    logic signed [P_W-1:0]   prod_a;
    logic signed [P_W-1:0]   prod_b;
    logic [P_W-1:0]          rsum_a;
    logic [P_W-1:0]          rsum_b;
    logic [T_W-1:0]          rnd_a;
    logic [T_W-1:0]          rnd_b;
    logic [W_W-1:0]          rnd_b3;
    logic [W_W-1:0]          rnd_a3;
    logic [ACC_W-1:0]        rx_sum;
    logic [ACC_W-1:0]        rz_sum;
    logic signed [S_W-1:0]   sum_x;
    logic signed [S_W-1:0]   sum_z;
    logic signed [POS_W-1:0] sat_x;
    logic signed [POS_W-1:0] sat_z;
    logic [T_W:0]            t_next;
    logic [SEG_W:0]          seg_inc;

    assign uw          = uc_rom(r_pc);
    assign o_ready     = !r_busy;
    assign in_acc      = i_valid && !r_busy;
    assign o_cfg_ready = 1'b1;
    assign stall       = (uw.op == UOP_FINISH) && r_o_valid && !i_ready;

    // Next step: an accepted word starts the program at the dispatch step, a finishing
    // word returns to idle, and the dispatch step branches on loads.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_valid) begin
                n_busy = 1'b1;
                n_pc   = '0;
            end
        end else if (!stall) begin
            if (uw.last) begin
                n_busy = 1'b0;
                n_pc   = '0;
            end else if (uw.cond == COND_LOAD && r_op == OP_LOAD) begin
                n_pc = uw.target;
            end else begin
                n_pc = r_pc + PC_W'(1);
            end
        end
    end

    always_comb begin
        t_c  = (r_t > T_ONE) ? T_ONE : r_t;
        u_c  = T_ONE - t_c;
        // Segment s starts at point 3s; the micro-op offset picks one of its four points.
        pidx = IDX_W'({r_seg, 1'b0}) + IDX_W'(r_seg) + IDX_W'(uw.ofs);
        px4  = {r_cpx[pidx], 2'b00};
        pz4  = {r_cpz[pidx], 2'b00};
        ma_a = PA_W'(t_c);
        mb_a = PB_W'(t_c);
        ma_b = PA_W'(u_c);
        mb_b = PB_W'(u_c);
        unique case (uw.op)
            UOP_CUBE_U: begin
                ma_a = PA_W'(r_u2);
                mb_a = PB_W'(u_c);
                ma_b = PA_W'(r_u2);
                mb_b = PB_W'(t_c);
            end
            UOP_CUBE_T: begin
                ma_a = PA_W'(r_t2);
                mb_a = PB_W'(u_c);
                ma_b = PA_W'(r_t2);
                mb_b = PB_W'(t_c);
            end
            UOP_MAC: begin
                ma_a = PA_W'(r_w[uw.ofs]);
                mb_a = PB_W'(px4);
                ma_b = PA_W'(r_w[uw.ofs]);
                mb_b = PB_W'(pz4);
            end
            default: begin
                ma_a = PA_W'(t_c);
                mb_a = PB_W'(t_c);
                ma_b = PA_W'(u_c);
                mb_b = PB_W'(u_c);
            end
        endcase
        prod_a = ma_a * mb_a;
        prod_b = ma_b * mb_b;
        // Weight products are never negative; round half up and drop the fraction.
        rsum_a = prod_a + RND_HALF;
        rsum_b = prod_b + RND_HALF;
        rnd_a  = rsum_a[PARAM_FRAC_BITS+T_W-1:PARAM_FRAC_BITS];
        rnd_b  = rsum_b[PARAM_FRAC_BITS+T_W-1:PARAM_FRAC_BITS];
        rnd_a3 = W_W'(rnd_a) + W_W'({rnd_a, 1'b0});
        rnd_b3 = W_W'(rnd_b) + W_W'({rnd_b, 1'b0});
        // Arithmetic shift of the rounded sum gives the floor.
        rx_sum = r_acc_x + ACC_HALF;
        rz_sum = r_acc_z + ACC_HALF;
        sum_x  = S_W'(r_cv_x) + S_W'(r_cx);
        sum_z  = S_W'(r_cv_z) + S_W'(r_cz);
        if (sum_x > POS_MAX) begin
            sat_x = POS_MAX[POS_W-1:0];
        end else if (sum_x < POS_MIN) begin
            sat_x = POS_MIN[POS_W-1:0];
        end else begin
            sat_x = sum_x[POS_W-1:0];
        end
        if (sum_z > POS_MAX) begin
            sat_z = POS_MAX[POS_W-1:0];
        end else if (sum_z < POS_MIN) begin
            sat_z = POS_MIN[POS_W-1:0];
        end else begin
            sat_z = sum_z[POS_W-1:0];
        end
        t_next  = {1'b0, t_c} + (T_W + 1)'(r_step);
        seg_inc = {1'b0, r_seg} + (SEG_W + 1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pc      <= '0;
            r_o_valid <= 1'b0;
            r_step    <= STEP_RESET;
            r_cx      <= '0;
            r_cy      <= '0;
            r_cz      <= '0;
            r_t       <= '0;
            r_seg     <= SEG_W'(1 % NUM_SEGMENTS);
            for (int i = 0; i < NUM_POINTS; i++) begin
                r_cpx[i] <= (i < TABLE_POINTS) ? init_x(i) : '0;
                r_cpz[i] <= (i < TABLE_POINTS) ? init_z(i) : '0;
            end
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;

            if (in_acc) begin
                r_op   <= i_op;
                r_idx  <= i_point_index;
                r_px   <= i_point_x;
                r_pz   <= i_point_z;
            end

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STEP:     r_step <= i_cfg_data[STEP_W-1:0];
                    CFG_CENTER_X: r_cx   <= i_cfg_data[POS_W-1:0];
                    CFG_CENTER_Y: r_cy   <= i_cfg_data[POS_W-1:0];
                    CFG_CENTER_Z: r_cz   <= i_cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end

            // A finish step in the same cycle refills the result register instead.
            if (r_o_valid && i_ready && !(r_busy && uw.op == UOP_FINISH)) begin
                r_o_valid <= 1'b0;
            end

            if (r_busy && !stall) begin
                unique case (uw.op)
                    UOP_DISPATCH: ;
                    UOP_SQUARE: begin
                        r_t2 <= rnd_a;
                        r_u2 <= rnd_b;
                    end
                    UOP_CUBE_U: begin
                        r_w[0] <= W_W'(rnd_a);
                        r_w[1] <= rnd_b3;
                    end
                    UOP_CUBE_T: begin
                        r_w[2] <= rnd_a3;
                        r_w[3] <= W_W'(rnd_b);
                    end
                    UOP_MAC: begin
                        if (uw.ofs == 2'd0) begin
                            r_acc_x <= ACC_W'(prod_a);
                            r_acc_z <= ACC_W'(prod_b);
                        end else begin
                            r_acc_x <= r_acc_x + ACC_W'(prod_a);
                            r_acc_z <= r_acc_z + ACC_W'(prod_b);
                        end
                    end
                    UOP_ROUND: begin
                        r_cv_x <= rx_sum[ACC_W-1:PARAM_FRAC_BITS];
                        r_cv_z <= rz_sum[ACC_W-1:PARAM_FRAC_BITS];
                    end
                    UOP_FINISH: begin
                        r_o_valid  <= 1'b1;
                        r_pos_x    <= sat_x;
                        r_pos_y    <= r_cy;
                        r_pos_z    <= sat_z;
                        r_seg_used <= r_seg;
                        // Past 1.0 the parameter restarts on the next segment.
                        if (t_next > (T_W + 1)'(T_ONE)) begin
                            r_t <= '0;
                            if (seg_inc >= (SEG_W + 1)'(NUM_SEGMENTS)) begin
                                r_seg <= '0;
                            end else begin
                                r_seg <= seg_inc[SEG_W-1:0];
                            end
                        end else begin
                            r_t <= t_next[T_W-1:0];
                        end
                    end
                    UOP_LOAD: begin
                        // Indexes beyond the store are dropped.
                        if (r_idx < IDX_W'(NUM_POINTS)) begin
                            r_cpx[r_idx] <= r_px;
                            r_cpz[r_idx] <= r_pz;
                        end
                    end
                endcase
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_pos_x        = r_pos_x;
    assign o_pos_y        = r_pos_y;
    assign o_pos_z        = r_pos_z;
    assign o_segment_used = r_seg_used;

endmodule

// File: bench/tb_piecewise_bezier_path_walker_core.sv
// Self-checking testbench for the piecewise Bezier path walker core.
module tb_piecewise_bezier_path_walker_core;
    import pbpw_pkg::*;

    localparam int HALF_PERIOD  = 10;
    // This many quiet cycles after the last result word are enough for the block to
    // finish anything still in flight.
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 123;
    localparam int PLAN_ROWS    = 38;
    localparam int END_WAIT     = 5000;
    // The limit lies well beyond the slowest correct run.
    localparam longint RUN_LIMIT = 64'd10_000_000;

    localparam longint T_UNIT     = longint'(1) << PARAM_FRAC_BITS;
    localparam longint T_HALF_LSB = longint'(1) << (PARAM_FRAC_BITS - 1);
    localparam longint POS_TOP    = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POS_BOTTOM = -(longint'(1) << (POS_W - 1));

    localparam logic signed [PT_W-1:0]  COORD_MAX  = {1'b0, {(PT_W - 1){1'b1}}};
    localparam logic signed [PT_W-1:0]  COORD_MIN  = {1'b1, {(PT_W - 1){1'b0}}};
    localparam logic [CFG_W-1:0]        CENTER_MAX = {1'b0, {(CFG_W - 1){1'b1}}};
    localparam logic [CFG_W-1:0]        CENTER_MIN = {1'b1, {(CFG_W - 1){1'b0}}};
    localparam logic [STEP_W-1:0]       STEP_MAX   = {STEP_W{1'b1}};

    // Register indexes past the end of the register list; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(15);

    // One result word: the position and the segment it came from.
    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [SEG_W-1:0]        seg;
    } t_pos_word;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_TICK} t_row_kind;

    // A row of the directed plan. Register writes use sel and a, loads use idx, a and b,
    // and a tick with typed set carries its result word in ex, ey, ez and es.
    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] sel;
        logic [IDX_W-1:0]     idx;
        int                   a;
        int                   b;
        bit                   typed;
        int                   ex;
        int                   ey;
        int                   ez;
        int                   es;
    } t_plan_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic                       i_op;
    logic [IDX_W-1:0]           i_point_index;
    logic signed [PT_W-1:0]     i_point_x;
    logic signed [PT_W-1:0]     i_point_z;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [POS_W-1:0]    o_pos_x;
    logic signed [POS_W-1:0]    o_pos_y;
    logic signed [POS_W-1:0]    o_pos_z;
    logic [SEG_W-1:0]           o_segment_used;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_data;

    // Shadow copy of the block: registers, curve parameter, segment and point store.
    logic [STEP_W-1:0]          step_reg;
    logic signed [CFG_W-1:0]    ctr_x;
    logic signed [CFG_W-1:0]    ctr_y;
    logic signed [CFG_W-1:0]    ctr_z;
    longint                     cur_t;
    int                         cur_seg;
    longint                     path_x [NUM_POINTS];
    longint                     path_z [NUM_POINTS];

    t_pos_word                  pos_expected [$];
    int                         fail_count;

    // Traffic controls shared by the sender, the receiver and the sequence.
    bit                         send_jitter;
    bit                         ready_jitter;
    bit                         hold_req;

    // The path the block holds after reset, in Q7.8.
    int reset_x [TABLE_POINTS] = '{
        0, 584, 1009, 1147, 1203, 1065, 768, 420, -118, -440,
        -773, -440, -31, 512, 148, -353, -1075, -297, 0};
    int reset_z [TABLE_POINTS] = '{
        0, -77, -435, -881, -1398, -1894, -2043, -2140, -2094, -1705,
        -1229, -1162, -1116, -1085, -819, -486, 61, 67, 0};

    // Directed plan. With the step at one half, a segment is visited at t = 0, 0.5
    // and exactly 1.0; the ends give the first and the last point of the segment
    // times four, so those rows carry their result word. A step of 0xFFFF walks
    // two ticks per segment and shows the wrap from the last segment back to the
    // first; a step of zero freezes the walk.
    t_plan_row plan [PLAN_ROWS] = '{
        '{ROW_CFG,  CFG_STEP,     '0, 32768, 0, 0, 0, 0, 0, 0},
        // Reset path, first tick: segment 1 at t = 0 gives point 3 times four.
        '{ROW_TICK, '0, '0, 0, 0, 1, 4588, 0, -3524, 1},
        '{ROW_TICK, '0, '0, 0, 0, 0, 0, 0, 0, 0},
        // t reaches exactly 1.0 and is kept, so point 6 comes out.
        '{ROW_TICK, '0, '0, 0, 0, 1, 3072, 0, -8172, 1},
        // Loads at and past the end of the point store are dropped.
        '{ROW_LOAD, '0, 5'd19, 32767, -32768, 0, 0, 0, 0, 0},
        '{ROW_LOAD, '0, 5'd31, -32768, 32767, 0, 0, 0, 0, 0},
        '{ROW_LOAD, '0, 5'd6, 32767, -32768, 0, 0, 0, 0, 0},
        '{ROW_LOAD, '0, 5'd9, -32768, 32767, 0, 0, 0, 0, 0},
        '{ROW_TICK, '0, '0, 0, 0, 1, 131068, 0, -131072, 2},
        '{ROW_TICK, '0, '0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, '0, '0, 0, 0, 1, -131072, 0, 131068, 2},
        '{ROW_CFG,  CFG_CENTER_X, '0, 8388607, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_CENTER_Y, '0, -8388608, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_CENTER_Z, '0, -8388608, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG,  REG_SPARE_LO, '0, 16777215, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG,  REG_SPARE_HI, '0, 5, 0, 0, 0, 0, 0, 0},
        '{ROW_LOAD, '0, 5'd9, 32767, -32768, 0, 0, 0, 0, 0},
        // Extreme point plus extreme center saturates both ways.
        '{ROW_TICK, '0, '0, 0, 0, 1, 8388607, -8388608, -8388608, 3},
        '{ROW_CFG,  CFG_CENTER_X, '0, -8388608, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_CENTER_Y, '0, 8388607, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_CENTER_Z, '0, 8388607, 0, 0, 0, 0, 0, 0},
        '{ROW_LOAD, '0, 5'd12, -32768, 32767, 0, 0, 0, 0, 0},
        '{ROW_TICK, '0, '0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, '0, '0, 0, 0, 1, -8388608, 8388607, 8388607, 3},
        '{ROW_CFG,  CFG_STEP,     '0, 65535, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_CENTER_X, '0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_CENTER_Y, '0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_CENTER_Z, '0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, '0, '0, 0, 0, 1, -131072, 0, 131068, 4},
        '{ROW_TICK, '0, '0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, '0, '0, 0, 0, 1, -1412, 0, -1944, 5},
        '{ROW_TICK, '0, '0, 0, 0, 0, 0, 0, 0, 0},
        // The walk has wrapped from the last segment back to segment 0.
        '{ROW_TICK, '0, '0, 0, 0, 1, 0, 0, 0, 0},
        '{ROW_TICK, '0, '0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_STEP,     '0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_LOAD, '0, 5'd3, -256, 256, 0, 0, 0, 0, 0},
        // With a zero step the walk stands still at t = 0 of segment 1.
        '{ROW_TICK, '0, '0, 0, 0, 1, -1024, 0, 1024, 1},
        '{ROW_TICK, '0, '0, 0, 0, 1, -1024, 0, 1024, 1}
    };

    piecewise_bezier_path_walker_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_point_index  (i_point_index),
        .i_point_x      (i_point_x),
        .i_point_z      (i_point_z),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_segment_used (o_segment_used),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Round a non-negative product back to the parameter's fraction width.
    function automatic longint frac_round(input longint a);
        return (a + T_HALF_LSB) >>> PARAM_FRAC_BITS;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > POS_TOP) begin
            return POS_W'(POS_TOP);
        end
        if (v < POS_BOTTOM) begin
            return POS_W'(POS_BOTTOM);
        end
        return POS_W'(v);
    endfunction

    // Evaluates the current segment at the current t, then advances t and the segment
    // the way the block does. The Bernstein weights are built from rounded products,
    // the weighted sum of the points times four is rounded half up to Q.8 and the
    // center is added with saturation.
    function automatic t_pos_word walk_tick();
        t_pos_word r;
        longint    t;
        longint    u;
        longint    t2;
        longint    u2;
        longint    w [4];
        longint    acc_x;
        longint    acc_z;
        int        base;
        t     = (cur_t > T_UNIT) ? T_UNIT : cur_t;
        u     = T_UNIT - t;
        t2    = frac_round(t * t);
        u2    = frac_round(u * u);
        w[0]  = frac_round(u2 * u);
        w[1]  = 3 * frac_round(u2 * t);
        w[2]  = 3 * frac_round(t2 * u);
        w[3]  = frac_round(t2 * t);
        base  = 3 * cur_seg;
        acc_x = 0;
        acc_z = 0;
        for (int i = 0; i < 4; i++) begin
            acc_x += w[i] * 4 * path_x[base + i];
            acc_z += w[i] * 4 * path_z[base + i];
        end
        r.x   = clamp_pos(((acc_x + T_HALF_LSB) >>> PARAM_FRAC_BITS) + longint'(ctr_x));
        r.z   = clamp_pos(((acc_z + T_HALF_LSB) >>> PARAM_FRAC_BITS) + longint'(ctr_z));
        r.y   = ctr_y;
        r.seg = SEG_W'(cur_seg);
        // t = 1.0 itself is kept; only a step past it wraps to the next segment.
        cur_t = t + longint'(step_reg);
        if (cur_t > T_UNIT) begin
            cur_t = 0;
            cur_seg++;
            if (cur_seg >= NUM_SEGMENTS) begin
                cur_seg = 0;
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [POS_W:0] want,
                                        input logic signed [POS_W:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic logic signed [PT_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            default: return PT_W'($urandom);
        endcase
    endfunction

    // Half the centers are modest so the curve still shows; the rest are extremes or
    // anything at all, which drives the saturation.
    function automatic logic [CFG_W-1:0] pick_center();
        case ($urandom_range(0, 5))
            0: return CENTER_MAX;
            1: return CENTER_MIN;
            2: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(0, 1 << 21) - (1 << 20));
        endcase
    endfunction

    // Offers one input word from the next falling edge and holds it until accepted.
    // Valid stays high on return; the caller lowers it when a gap follows.
    task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                             input logic signed [PT_W-1:0] px,
                             input logic signed [PT_W-1:0] pz,
                             input bit typed, input t_pos_word want);
        t_pos_word got;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_op          <= op;
        i_point_index <= idx;
        i_point_x     <= px;
        i_point_z     <= pz;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op == OP_TICK) begin
            got = walk_tick();
            if (typed) begin
                pos_expected.push_back(want);
            end else begin
                pos_expected.push_back(got);
            end
        end else if (idx < NUM_POINTS) begin
            path_x[idx] = longint'(px);
            path_z[idx] = longint'(pz);
        end
    endtask

    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Stops offering, waits for every expected result word, then lets a possible
    // trailing load finish.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pos_expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] data);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (sel)
            CFG_STEP:     step_reg = data[STEP_W-1:0];
            CFG_CENTER_X: ctr_x = data;
            CFG_CENTER_Y: ctr_y = data;
            CFG_CENTER_Z: ctr_z = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Every accepted result word is matched against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_pos_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pos_expected.size() == 0) begin
                fail_count++;
                $display("%0t: result word with nothing expected, expected none, %s",
                         $time, "got");
                $display("%0t:   %0d %0d %0d seg %0d", $time, o_pos_x, o_pos_y, o_pos_z,
                         o_segment_used);
            end else begin
                want = pos_expected.pop_front();
                check_field("pos_x", (POS_W + 1)'(want.x), (POS_W + 1)'(o_pos_x));
                check_field("pos_y", (POS_W + 1)'(want.y), (POS_W + 1)'(o_pos_y));
                check_field("pos_z", (POS_W + 1)'(want.z), (POS_W + 1)'(o_pos_z));
                check_field("segment_used", (POS_W + 1)'(want.seg),
                            (POS_W + 1)'(o_segment_used));
            end
        end
    end

    // Receiver. Ready drops in random bursts while jitter is on; on request it holds
    // off for a long stretch so the block fills up and stalls its input.
    initial begin
        int n;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (ready_jitter && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 14);
                i_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Sequence: reset, the directed plan, then random phases each opened by fresh
    // register settings. The last phase runs with no idling on either side.
    initial begin
        t_plan_row         row;
        t_pos_word         want;
        logic [STEP_W-1:0] step_pick;
        logic [IDX_W-1:0]  pidx;
        bit                quiet;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_op          = OP_TICK;
        i_point_index = '0;
        i_point_x     = '0;
        i_point_z     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_STEP;
        i_cfg_data    = '0;
        fail_count    = 0;
        send_jitter   = 1'b0;
        ready_jitter  = 1'b1;
        hold_req      = 1'b0;
        want          = '{x: '0, y: '0, z: '0, seg: '0};

        step_reg = STEP_RESET;
        ctr_x    = '0;
        ctr_y    = '0;
        ctr_z    = '0;
        cur_t    = 0;
        cur_seg  = 1 % NUM_SEGMENTS;
        for (int i = 0; i < NUM_POINTS; i++) begin
            path_x[i] = longint'((i < TABLE_POINTS) ? reset_x[i] : 0);
            path_z[i] = longint'((i < TABLE_POINTS) ? reset_z[i] : 0);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            row      = plan[r];
            want.x   = POS_W'(row.ex);
            want.y   = POS_W'(row.ey);
            want.z   = POS_W'(row.ez);
            want.seg = SEG_W'(row.es);
            case (row.kind)
                ROW_CFG:  write_reg(row.sel, CFG_W'(row.a));
                ROW_LOAD: send_word(OP_LOAD, row.idx, PT_W'(row.a), PT_W'(row.b), 1'b0, want);
                default:  send_word(OP_TICK, '0, '0, '0, row.typed, want);
            endcase
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiet        = (ph == NUM_PHASES - 1);
            send_jitter  = !quiet && (ph % 3 != 1);
            ready_jitter = !quiet && (ph % 3 != 2);

            case ($urandom_range(0, 9))
                0: step_pick = '0;
                1: step_pick = STEP_MAX;
                2: step_pick = STEP_W'(T_UNIT >> 1);
                3: step_pick = STEP_W'($urandom_range(1, 500));
                default: step_pick = STEP_W'($urandom);
            endcase
            // The unused upper data bits get noise; only the low 16 belong to the step.
            write_reg(CFG_STEP, {(CFG_W - STEP_W)'($urandom), step_pick});
            write_reg(CFG_CENTER_X, pick_center());
            write_reg(CFG_CENTER_Y, pick_center());
            write_reg(CFG_CENTER_Z, pick_center());
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                          CFG_W'($urandom));
            end

            // In one phase the receiver stops for a long while as the words keep coming.
            if (ph == 2) begin
                hold_req = 1'b1;
            end

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Once mid-phase the sender waits until every result word is back.
                if (ph == 4 && k == PHASE_ITEMS / 2) begin
                    settle();
                end
                if (send_jitter && $urandom_range(0, 7) == 0) begin
                    pause_sender($urandom_range(1, 14));
                end
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 9) == 0) begin
                        pidx = IDX_W'($urandom);
                    end else begin
                        pidx = IDX_W'($urandom_range(0, NUM_POINTS - 1));
                    end
                    send_word(OP_LOAD, pidx, pick_coord(), pick_coord(), 1'b0, want);
                end else begin
                    // Tick words carry random payload that the block must ignore.
                    send_word(OP_TICK, IDX_W'($urandom), pick_coord(), pick_coord(),
                              1'b0, want);
                end
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        for (int c = 0; c < END_WAIT && pos_expected.size() != 0; c++) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pos_expected.size() != 0) begin
            fail_count++;
            $display("%0t: result words expected %0d more, got none", $time,
                     pos_expected.size());
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
